// ===== hdl/ehp_pkg.sv =====
package ehp_pkg;

    // Frame size limit; the byte counter saturates here.
    localparam int MAX_FRAME = 65536;
    localparam int POS_W     = $clog2(MAX_FRAME + 1);

    localparam logic [POS_W-1:0] POS_MAX    = POS_W'(MAX_FRAME);
    localparam logic [POS_W-1:0] ETH_HDR    = POS_W'(14);
    localparam logic [POS_W-1:0] IP_MIN_HDR = POS_W'(20);
    localparam logic [POS_W-1:0] TCP_HDR    = POS_W'(20);
    localparam logic [POS_W-1:0] UDP_HDR    = POS_W'(8);
    localparam logic [POS_W-1:0] ICMP_HDR   = POS_W'(8);
    localparam logic [POS_W-1:0] L4_CAPTURE = POS_W'(20);

    // Fixed byte offsets of the Ethernet and IPv4 header fields in the frame
    localparam logic [POS_W-1:0] OFS_VIHL    = POS_W'(14);
    localparam logic [POS_W-1:0] OFS_LEN_HI  = POS_W'(16);
    localparam logic [POS_W-1:0] OFS_LEN_LO  = POS_W'(17);
    localparam logic [POS_W-1:0] OFS_TTL     = POS_W'(22);
    localparam logic [POS_W-1:0] OFS_PROTO   = POS_W'(23);
    localparam logic [POS_W-1:0] OFS_SIP     = POS_W'(26);
    localparam logic [POS_W-1:0] OFS_DIP     = POS_W'(30);
    localparam logic [POS_W-1:0] OFS_DIP_END = POS_W'(34);
    localparam logic [POS_W-1:0] OFS_SMAC    = POS_W'(6);
    localparam logic [POS_W-1:0] OFS_TYPE    = POS_W'(12);

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [3:0]  IP_VERSION = 4'd4;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // Status codes
    localparam logic [3:0] ST_TCP       = 4'd0;
    localparam logic [3:0] ST_UDP       = 4'd1;
    localparam logic [3:0] ST_ICMP      = 4'd2;
    localparam logic [3:0] ST_IP_OTHER  = 4'd3;
    localparam logic [3:0] ST_IP_TRUNC  = 4'd4;
    localparam logic [3:0] ST_IP_BAD    = 4'd5;
    localparam logic [3:0] ST_TCP_TRUNC = 4'd6;
    localparam logic [3:0] ST_UDP_TRUNC = 4'd7;
    localparam logic [3:0] ST_ICMP_TRUNC = 4'd8;
    localparam logic [3:0] ST_IPV6      = 4'd9;
    localparam logic [3:0] ST_ARP       = 4'd10;
    localparam logic [3:0] ST_NON_IP    = 4'd11;

    // Raw captures of one finished frame, handed from front to back
    typedef struct packed {
        logic [POS_W-1:0] frame_length;
        logic [47:0]      dest_mac;
        logic [47:0]      source_mac;
        logic [15:0]      frame_type;
        logic [7:0]       vihl;
        logic [7:0]       ttl;
        logic [7:0]       protocol;
        logic [15:0]      ip_length;
        logic [31:0]      source_ip;
        logic [31:0]      dest_ip;
        logic [15:0]      l4_w0;
        logic [15:0]      l4_w1;
        logic [15:0]      l4_w2;
    } t_frame_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Result fields, last field (status) in the lowest bits
    typedef struct packed {
        logic [15:0]      l4_third;
        logic [15:0]      l4_second;
        logic [15:0]      l4_first;
        logic [15:0]      ip_length;
        logic [7:0]       time_to_live;
        logic [31:0]      dest_ip;
        logic [31:0]      source_ip;
        logic [15:0]      frame_type;
        logic [47:0]      source_mac;
        logic [47:0]      dest_mac;
        logic [POS_W-1:0] frame_length;
        logic [3:0]       status;
    } t_result;

    localparam int RES_W  = $bits(t_result);
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

// ===== hdl/ehp_front.sv =====
module ehp_front
    import ehp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_push,
    output t_frame_rec o_rec
);

    logic [POS_W-1:0] r_pos,   n_pos;
    logic [47:0]      r_dmac,  n_dmac;
    logic [47:0]      r_smac,  n_smac;
    logic [15:0]      r_type,  n_type;
    logic [7:0]       r_vihl,  n_vihl;
    logic [7:0]       r_ttl,   n_ttl;
    logic [7:0]       r_proto, n_proto;
    logic [15:0]      r_iplen, n_iplen;
    logic [31:0]      r_sip,   n_sip;
    logic [31:0]      r_dip,   n_dip;
    logic [15:0]      r_w0,    n_w0;
    logic [15:0]      r_w1,    n_w1;
    logic [15:0]      r_w2,    n_w2;

    logic             take;
    logic [POS_W-1:0] l4_start;
    logic [POS_W-1:0] rel;
    logic             in_l4;
    logic [7:0]       proto_now;

    assign take      = (r_pos < POS_MAX);
    assign l4_start  = ETH_HDR + POS_W'({r_vihl[3:0], 2'b00});
    assign rel       = r_pos - l4_start;
    assign in_l4     = (r_pos > OFS_VIHL) && (r_pos >= l4_start) && (rel < L4_CAPTURE);
    // protocol byte counts as seen in the same cycle it arrives
    assign proto_now = (r_pos == OFS_PROTO) ? i_data_byte : r_proto;

    always_comb begin
        n_pos   = r_pos;
        n_dmac  = r_dmac;
        n_smac  = r_smac;
        n_type  = r_type;
        n_vihl  = r_vihl;
        n_ttl   = r_ttl;
        n_proto = r_proto;
        n_iplen = r_iplen;
        n_sip   = r_sip;
        n_dip   = r_dip;
        n_w0    = r_w0;
        n_w1    = r_w1;
        n_w2    = r_w2;
        if (take) begin
            n_pos = r_pos + POS_W'(1);
            if (r_pos < OFS_SMAC) begin
                n_dmac = {r_dmac[39:0], i_data_byte};
            end else if (r_pos < OFS_TYPE) begin
                n_smac = {r_smac[39:0], i_data_byte};
            end else if (r_pos < OFS_VIHL) begin
                n_type = {r_type[7:0], i_data_byte};
            end else if (r_pos == OFS_VIHL) begin
                n_vihl = i_data_byte;
            end else if (r_pos == OFS_LEN_HI || r_pos == OFS_LEN_LO) begin
                n_iplen = {r_iplen[7:0], i_data_byte};
            end else if (r_pos == OFS_TTL) begin
                n_ttl = i_data_byte;
            end else if (r_pos == OFS_PROTO) begin
                n_proto = i_data_byte;
            end else if (r_pos >= OFS_SIP && r_pos < OFS_DIP) begin
                n_sip = {r_sip[23:0], i_data_byte};
            end else if (r_pos >= OFS_DIP && r_pos < OFS_DIP_END) begin
                n_dip = {r_dip[23:0], i_data_byte};
            end
            if (in_l4) begin
                if (rel < POS_W'(2)) begin
                    n_w0 = {r_w0[7:0], i_data_byte};
                end else if (rel < POS_W'(4)) begin
                    n_w1 = {r_w1[7:0], i_data_byte};
                end else if (proto_now == PROTO_TCP) begin
                    if (rel == POS_W'(13)) begin
                        n_w2 = {10'd0, i_data_byte[5:0]};
                    end
                end else if (rel < POS_W'(6)) begin
                    n_w2 = {r_w2[7:0], i_data_byte};
                end
            end
        end
    end

    // Hand the finished frame over; runts are dropped
    assign o_push = i_fire && i_last_byte && (n_pos >= ETH_HDR);

    assign o_rec.frame_length = n_pos;
    assign o_rec.dest_mac     = n_dmac;
    assign o_rec.source_mac   = n_smac;
    assign o_rec.frame_type   = n_type;
    assign o_rec.vihl         = n_vihl;
    assign o_rec.ttl          = n_ttl;
    assign o_rec.protocol     = n_proto;
    assign o_rec.ip_length    = n_iplen;
    assign o_rec.source_ip    = n_sip;
    assign o_rec.dest_ip      = n_dip;
    assign o_rec.l4_w0        = n_w0;
    assign o_rec.l4_w1        = n_w1;
    assign o_rec.l4_w2        = n_w2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last_byte)) begin
            r_pos   <= '0;
            r_dmac  <= '0;
            r_smac  <= '0;
            r_type  <= '0;
            r_vihl  <= '0;
            r_ttl   <= '0;
            r_proto <= '0;
            r_iplen <= '0;
            r_sip   <= '0;
            r_dip   <= '0;
            r_w0    <= '0;
            r_w1    <= '0;
            r_w2    <= '0;
        end else if (i_fire) begin
            r_pos   <= n_pos;
            r_dmac  <= n_dmac;
            r_smac  <= n_smac;
            r_type  <= n_type;
            r_vihl  <= n_vihl;
            r_ttl   <= n_ttl;
            r_proto <= n_proto;
            r_iplen <= n_iplen;
            r_sip   <= n_sip;
            r_dip   <= n_dip;
            r_w0    <= n_w0;
            r_w1    <= n_w1;
            r_w2    <= n_w2;
        end
    end

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("byte counter past frame limit");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_last_byte) |=> (r_pos == '0 && r_vihl == '0))
        else $error("capture state not cleared after last byte");

endmodule

// ===== hdl/ehp_queue.sv =====
module ehp_queue
    import ehp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_frame_rec i_rec,
    input  logic       i_pop,
    output t_frame_rec o_rec,
    output t_q_status  o_stat
);

    localparam int DEPTH = 2;

    t_frame_rec r_mem [DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_stat.full  = (r_count == 2'(DEPTH));
    assign o_stat.empty = (r_count == 2'd0);
    assign o_rec        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(DEPTH))
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("pop from empty queue");

endmodule

// ===== hdl/ehp_back.sv =====
module ehp_back
    import ehp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_frame_rec i_rec,
    input  t_q_status  i_stat,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output t_result    o_res
);

    logic             r_valid;
    t_result          r_res;
    t_result          n_res;
    logic [3:0]       st;
    logic [POS_W-1:0] avail;
    logic [POS_W-1:0] hl;
    logic [POS_W-1:0] rem;
    logic             ip_ok;
    logic             l4_ok;

    assign avail = i_rec.frame_length - ETH_HDR;
    assign hl    = POS_W'({i_rec.vihl[3:0], 2'b00});
    assign rem   = avail - hl;

    always_comb begin
        if (i_rec.frame_type == ETYPE_IPV6) begin
            st = ST_IPV6;
        end else if (i_rec.frame_type == ETYPE_ARP) begin
            st = ST_ARP;
        end else if (i_rec.frame_type != ETYPE_IPV4) begin
            st = ST_NON_IP;
        end else if (avail < IP_MIN_HDR) begin
            st = ST_IP_TRUNC;
        end else if (i_rec.vihl[7:4] != IP_VERSION || hl < IP_MIN_HDR || avail < hl) begin
            st = ST_IP_BAD;
        end else if (i_rec.protocol == PROTO_TCP) begin
            st = (rem < TCP_HDR) ? ST_TCP_TRUNC : ST_TCP;
        end else if (i_rec.protocol == PROTO_UDP) begin
            st = (rem < UDP_HDR) ? ST_UDP_TRUNC : ST_UDP;
        end else if (i_rec.protocol == PROTO_ICMP) begin
            st = (rem < ICMP_HDR) ? ST_ICMP_TRUNC : ST_ICMP;
        end else begin
            st = ST_IP_OTHER;
        end
    end

    assign ip_ok = (st <= ST_IP_OTHER) || (st >= ST_TCP_TRUNC && st <= ST_ICMP_TRUNC);
    assign l4_ok = (st <= ST_ICMP);

    always_comb begin
        n_res.status       = st;
        n_res.frame_length = i_rec.frame_length;
        n_res.dest_mac     = i_rec.dest_mac;
        n_res.source_mac   = i_rec.source_mac;
        n_res.frame_type   = i_rec.frame_type;
        n_res.source_ip    = ip_ok ? i_rec.source_ip : '0;
        n_res.dest_ip      = ip_ok ? i_rec.dest_ip : '0;
        n_res.time_to_live = ip_ok ? i_rec.ttl : '0;
        n_res.ip_length    = ip_ok ? i_rec.ip_length : '0;
        n_res.l4_first     = '0;
        n_res.l4_second    = '0;
        n_res.l4_third     = '0;
        if (l4_ok) begin
            if (st == ST_ICMP) begin
                n_res.l4_first  = {8'd0, i_rec.l4_w0[15:8]};
                n_res.l4_second = {8'd0, i_rec.l4_w0[7:0]};
            end else begin
                n_res.l4_first  = i_rec.l4_w0;
                n_res.l4_second = i_rec.l4_w1;
                n_res.l4_third  = i_rec.l4_w2;
            end
        end
    end

    // Refill the output register when it is empty or being drained
    assign o_pop   = !i_stat.empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_valid)
        else $error("popped frame not presented");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_res.status <= ST_NON_IP))
        else $error("status code out of range");

endmodule

// ===== hdl/ethernet_ipv4_header_parser_unit.sv =====
// Ethernet / IPv4 / TCP / UDP / ICMP header parser, one byte per cycle.
// Throughput: one byte transfer every cycle; the front stalls only while the
// two-entry frame queue is full, i.e. with three finished frames held by a stalled receiver.
// Path: the transfer of the last byte writes the frame into the queue; the status is
// then decoded from the queue into the output register once that register is free.
// Reset: i_rst_n synchronous, active low; clears byte capture, queue and output valid.
module ethernet_ipv4_header_parser_unit
    import ehp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // slave side: one frame byte per transfer
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,   // [7:0] data_byte
    input  logic               i_s_axis_tlast,   // last_byte
    // master side: one result per frame of 14 bytes or more
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // tdata from bit 0 up: status(4), frame_length(17), dest_mac(48),
    // source_mac(48), frame_type(16), source_ip(32), dest_ip(32),
    // time_to_live(8), ip_length(16), l4_first(16), l4_second(16),
    // l4_third(16), zero fill
    output logic [TDATA_W-1:0] o_m_axis_tdata
);

    logic       fire;
    logic       push;
    logic       pop;
    t_frame_rec rec_in;
    t_frame_rec rec_out;
    t_q_status  q_stat;
    t_result    res;

    // Accept bytes whenever the queue can take a finished frame
    assign o_s_axis_tready = !q_stat.full;
    assign fire            = i_s_axis_tvalid && o_s_axis_tready;

    // Front: byte counting and field capture
    ehp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_data_byte (i_s_axis_tdata),
        .i_last_byte (i_s_axis_tlast),
        .o_push      (push),
        .o_rec       (rec_in)
    );

    // Queue of finished frames between capture and decode
    ehp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec_in),
        .i_pop   (pop),
        .o_rec   (rec_out),
        .o_stat  (q_stat)
    );

    // Back: status decode, field masking, output register
    ehp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (rec_out),
        .i_stat  (q_stat),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res)
    );

    // Pad the result to whole bytes
    assign o_m_axis_tdata = {{(TDATA_W - RES_W){1'b0}}, res};

endmodule

// ===== sim/ethernet_ipv4_header_parser_unit_tb.sv =====
module ethernet_ipv4_header_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ehp_pkg::*;

    // A correct run moves about 2k bytes; the limit must also cover 55% sender idling
    // plus the long receiver hold-off.
    localparam int CYCLE_LIMIT = 100_000;
    localparam int MAX_REPORTS = 10;
    localparam int NUM_STATUS  = 12;
    localparam int NO_STATUS   = -1;    // row status taken from the local parser
    localparam int KEEP        = -1;    // leave the filled byte as it is

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;

    typedef struct {
        t_fill fill;
        int    len;
        int    etype;
        int    vihl;
        int    proto;
        int    status;
    } t_frame_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [7:0]         s_tdata = 8'h00;
    logic               s_tlast = 1'b0;
    logic               o_m_axis_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] o_m_axis_tdata;

    ethernet_ipv4_header_parser_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),      // [7:0] data_byte
        .i_s_axis_tlast  (s_tlast),      // last_byte
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        // status, frame_length, dest_mac, source_mac, frame_type, source_ip,
        // dest_ip, time_to_live, ip_length, l4_first, l4_second, l4_third, fill
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Local parser: captured header bytes of the frame in flight
    // ------------------------------------------------------------------
    int          cap_pos;
    logic [47:0] cap_dmac;
    logic [47:0] cap_smac;
    logic [15:0] cap_type;
    logic [7:0]  cap_vihl;
    logic [7:0]  cap_ttl;
    logic [7:0]  cap_proto;
    logic [15:0] cap_iplen;
    logic [31:0] cap_sip;
    logic [31:0] cap_dip;
    logic [15:0] cap_l4 [3];

    t_result     awaited_headers [$];
    logic [7:0]  frame_bytes [$];

    int          status_override = NO_STATUS;
    int          bytes_in;
    int          headers_predicted;
    int          headers_seen;
    int          runt_frames;
    int          oversized_frames;
    bit          status_hit [NUM_STATUS];
    int          err_count;
    int          cycle_count;

    int          src_idle_pct;
    int          sink_idle_pct;
    int          hold_len;
    int          hold_seq;

    function automatic void clear_capture();
        cap_pos   = 0;
        cap_dmac  = '0;
        cap_smac  = '0;
        cap_type  = '0;
        cap_vihl  = '0;
        cap_ttl   = '0;
        cap_proto = '0;
        cap_iplen = '0;
        cap_sip   = '0;
        cap_dip   = '0;
        for (int i = 0; i < 3; i++) cap_l4[i] = '0;
    endfunction

    // Shift one byte into whichever header field owns its offset.
    function automatic void capture_byte(int idx, logic [7:0] b);
        int l4_start;
        int rel;
        if (idx < int'(OFS_SMAC)) begin
            cap_dmac = {cap_dmac[39:0], b};
        end else if (idx < int'(OFS_TYPE)) begin
            cap_smac = {cap_smac[39:0], b};
        end else if (idx < int'(ETH_HDR)) begin
            cap_type = {cap_type[7:0], b};
        end else if (idx == int'(OFS_VIHL)) begin
            cap_vihl = b;
        end else if (idx == int'(OFS_LEN_HI) || idx == int'(OFS_LEN_LO)) begin
            cap_iplen = {cap_iplen[7:0], b};
        end else if (idx == int'(OFS_TTL)) begin
            cap_ttl = b;
        end else if (idx == int'(OFS_PROTO)) begin
            cap_proto = b;
        end else if (idx >= int'(OFS_SIP) && idx < int'(OFS_DIP)) begin
            cap_sip = {cap_sip[23:0], b};
        end else if (idx >= int'(OFS_DIP) && idx < int'(OFS_DIP_END)) begin
            cap_dip = {cap_dip[23:0], b};
        end

        // Layer-4 window follows the header length in force right now;
        // with a short IHL it overlaps the IP header and uses a stale protocol.
        if (idx > int'(OFS_VIHL)) begin
            l4_start = int'(ETH_HDR) + 4 * int'(cap_vihl[3:0]);
            if (idx >= l4_start && idx - l4_start < int'(L4_CAPTURE)) begin
                rel = idx - l4_start;
                if (rel < 2) begin
                    cap_l4[0] = {cap_l4[0][7:0], b};
                end else if (rel < 4) begin
                    cap_l4[1] = {cap_l4[1][7:0], b};
                end else if (cap_proto == PROTO_TCP) begin
                    if (rel == 13) cap_l4[2] = {10'd0, b[5:0]};
                end else if (rel < 6) begin
                    cap_l4[2] = {cap_l4[2][7:0], b};
                end
            end
        end
    endfunction

    function automatic logic [3:0] classify_frame(int len);
        int avail;
        int hl;
        int rem;
        if (cap_type == ETYPE_IPV6) return ST_IPV6;
        if (cap_type == ETYPE_ARP) return ST_ARP;
        if (cap_type != ETYPE_IPV4) return ST_NON_IP;
        avail = len - int'(ETH_HDR);
        if (avail < int'(IP_MIN_HDR)) return ST_IP_TRUNC;
        hl = 4 * int'(cap_vihl[3:0]);
        if (cap_vihl[7:4] != IP_VERSION || hl < int'(IP_MIN_HDR) || avail < hl)
            return ST_IP_BAD;
        rem = avail - hl;
        if (cap_proto == PROTO_TCP)
            return (rem < int'(TCP_HDR)) ? ST_TCP_TRUNC : ST_TCP;
        if (cap_proto == PROTO_UDP)
            return (rem < int'(UDP_HDR)) ? ST_UDP_TRUNC : ST_UDP;
        if (cap_proto == PROTO_ICMP)
            return (rem < int'(ICMP_HDR)) ? ST_ICMP_TRUNC : ST_ICMP;
        return ST_IP_OTHER;
    endfunction

    // Advance the parser by one accepted byte; on the last byte queue the
    // header record it should produce (none for a runt) and start over.
    function automatic void parse_byte(logic [7:0] b, logic last);
        t_result    hdr;
        logic [3:0] st;
        bit         ip_ok;
        bit         l4_ok;
        if (cap_pos < MAX_FRAME) begin
            capture_byte(cap_pos, b);
            cap_pos++;
        end
        if (!last) return;

        if (cap_pos < int'(ETH_HDR)) begin
            runt_frames++;
        end else begin
            st    = classify_frame(cap_pos);
            ip_ok = st <= ST_IP_OTHER || (st >= ST_TCP_TRUNC && st <= ST_ICMP_TRUNC);
            l4_ok = st <= ST_ICMP;
            hdr = '0;
            hdr.status       = st;
            hdr.frame_length = POS_W'(cap_pos);
            hdr.dest_mac     = cap_dmac;
            hdr.source_mac   = cap_smac;
            hdr.frame_type   = cap_type;
            if (ip_ok) begin
                hdr.source_ip    = cap_sip;
                hdr.dest_ip      = cap_dip;
                hdr.time_to_live = cap_ttl;
                hdr.ip_length    = cap_iplen;
            end
            if (l4_ok && st == ST_ICMP) begin
                hdr.l4_first  = {8'd0, cap_l4[0][15:8]};
                hdr.l4_second = {8'd0, cap_l4[0][7:0]};
            end else if (l4_ok) begin
                hdr.l4_first  = cap_l4[0];
                hdr.l4_second = cap_l4[1];
                hdr.l4_third  = cap_l4[2];
            end
            // Directed rows carry the status they must end in
            if (status_override != NO_STATUS) hdr.status = status_override[3:0];
            status_hit[st] = 1'b1;
            if (cap_pos == MAX_FRAME) oversized_frames++;
            awaited_headers.push_back(hdr);
            headers_predicted++;
        end
        clear_capture();
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("[%0t] mismatch on %s: expected %0h, got %0h (record %0d)",
                         $realtime, name, exp_v, act_v, headers_seen);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict on input transfers, check on output transfers
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (s_tvalid && o_s_axis_tready) begin
                bytes_in++;
                parse_byte(s_tdata, s_tlast);
            end
            if (o_m_axis_tvalid && m_tready) begin
                got = t_result'(o_m_axis_tdata[RES_W-1:0]);
                if (awaited_headers.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("[%0t] unexpected record: status %0d, length %0d",
                                 $realtime, got.status, got.frame_length);
                end else begin
                    want = awaited_headers.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("frame_length", 64'(want.frame_length),
                                64'(got.frame_length));
                    check_field("dest_mac", 64'(want.dest_mac), 64'(got.dest_mac));
                    check_field("source_mac", 64'(want.source_mac), 64'(got.source_mac));
                    check_field("frame_type", 64'(want.frame_type), 64'(got.frame_type));
                    check_field("source_ip", 64'(want.source_ip), 64'(got.source_ip));
                    check_field("dest_ip", 64'(want.dest_ip), 64'(got.dest_ip));
                    check_field("time_to_live", 64'(want.time_to_live),
                                64'(got.time_to_live));
                    check_field("ip_length", 64'(want.ip_length), 64'(got.ip_length));
                    check_field("l4_first", 64'(want.l4_first), 64'(got.l4_first));
                    check_field("l4_second", 64'(want.l4_second), 64'(got.l4_second));
                    check_field("l4_third", 64'(want.l4_third), 64'(got.l4_third));
                    check_field("zero fill", '0, 64'(o_m_axis_tdata >> RES_W));
                end
                headers_seen++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d records still awaited",
                     cycle_count, awaited_headers.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus long hold-offs on request
    // ------------------------------------------------------------------
    initial begin
        int hold_taken;
        int hold_left;
        hold_taken = 0;
        hold_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_seq != hold_taken) begin
                hold_taken = hold_seq;
                hold_left  = hold_len;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Offer one byte, idling at random first; returns at the falling edge
    // after the transfer with tvalid still high.
    task automatic push_byte(logic [7:0] b, logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            s_tdata  = 8'($urandom);
            s_tlast  = 1'($urandom);
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // Fill a frame, then overlay the header fields asked for.
    function automatic void build_frame(int len, t_fill fill, int etype, int vihl,
                                        int proto, bit fix_len);
        frame_bytes.delete();
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO: frame_bytes.push_back(8'h00);
                FILL_ONES: frame_bytes.push_back(8'hFF);
                default:   frame_bytes.push_back(8'($urandom));
            endcase
        end
        if (etype != KEEP && len > int'(OFS_TYPE) + 1) begin
            frame_bytes[OFS_TYPE]     = etype[15:8];
            frame_bytes[OFS_TYPE + 1] = etype[7:0];
        end
        if (vihl != KEEP && len > int'(OFS_VIHL)) frame_bytes[OFS_VIHL] = vihl[7:0];
        if (proto != KEEP && len > int'(OFS_PROTO)) frame_bytes[OFS_PROTO] = proto[7:0];
        if (fix_len && len > int'(OFS_LEN_LO)) begin
            frame_bytes[OFS_LEN_HI] = 8'((len - int'(ETH_HDR)) >> 8);
            frame_bytes[OFS_LEN_LO] = 8'(len - int'(ETH_HDR));
        end
    endfunction

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // Drop tvalid and hold until every awaited record has been checked.
    task automatic drain();
        s_tvalid = 1'b0;
        while (awaited_headers.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Ask the receiver to back off for a number of cycles.
    task automatic start_hold(int cycles);
        s_tvalid = 1'b0;
        @(posedge i_clk);
        hold_len = cycles;
        hold_seq++;
        @(negedge i_clk);
    endtask

    // One random frame; mostly well-formed IPv4 with random content.
    task automatic random_frame();
        int pick;
        int ihl;
        int hl;
        int need;
        int proto;
        int len;
        int etype;
        pick = $urandom_range(0, 99);
        ihl  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
        hl   = 4 * ihl;
        case ($urandom_range(0, 2))
            0:       begin proto = int'(PROTO_TCP);  need = int'(TCP_HDR);  end
            1:       begin proto = int'(PROTO_UDP);  need = int'(UDP_HDR);  end
            default: begin proto = int'(PROTO_ICMP); need = int'(ICMP_HDR); end
        endcase

        if (pick < 50) begin
            // complete layer-4 header
            len = int'(ETH_HDR) + hl + need + $urandom_range(0, 24);
            build_frame(len, FILL_RANDOM, int'(ETYPE_IPV4), int'({IP_VERSION, 4'(ihl)}),
                        proto, $urandom_range(0, 3) != 0);
        end else if (pick < 58) begin
            // layer-4 header cut short
            len = int'(ETH_HDR) + hl + $urandom_range(0, need - 1);
            build_frame(len, FILL_RANDOM, int'(ETYPE_IPV4), int'({IP_VERSION, 4'(ihl)}),
                        proto, 1'b1);
        end else if (pick < 62) begin
            // IP header cut short
            len = $urandom_range(int'(ETH_HDR), int'(ETH_HDR) + int'(IP_MIN_HDR) - 1);
            build_frame(len, FILL_RANDOM, int'(ETYPE_IPV4), int'({IP_VERSION, 4'd5}),
                        proto, 1'b0);
        end else if (pick < 68) begin
            // malformed: wrong version, short IHL, or header past the frame end
            case ($urandom_range(0, 2))
                0: begin
                    len = $urandom_range(34, 90);
                    build_frame(len, FILL_RANDOM, int'(ETYPE_IPV4),
                                int'({4'($urandom_range(0, 3) == 0 ? $urandom_range(0, 3)
                                                                    : $urandom_range(5, 15)),
                                      4'(ihl)}), proto, 1'b0);
                end
                1: begin
                    len = $urandom_range(34, 90);
                    build_frame(len, FILL_RANDOM, int'(ETYPE_IPV4),
                                int'({IP_VERSION, 4'($urandom_range(0, 4))}), proto, 1'b0);
                end
                default: begin
                    ihl = $urandom_range(6, 15);
                    len = $urandom_range(34, int'(ETH_HDR) + 4 * ihl - 1);
                    build_frame(len, FILL_RANDOM, int'(ETYPE_IPV4),
                                int'({IP_VERSION, 4'(ihl)}), proto, 1'b0);
                end
            endcase
        end else if (pick < 72) begin
            // valid IPv4, protocol other than TCP, UDP or ICMP
            do proto = $urandom_range(0, 255);
            while (proto == PROTO_TCP || proto == PROTO_UDP || proto == PROTO_ICMP);
            len = int'(ETH_HDR) + hl + $urandom_range(0, 30);
            build_frame(len, FILL_RANDOM, int'(ETYPE_IPV4), int'({IP_VERSION, 4'(ihl)}),
                        proto, 1'b1);
        end else if (pick < 76) begin
            build_frame($urandom_range(14, 80), FILL_RANDOM, int'(ETYPE_IPV6), KEEP, KEEP,
                        1'b0);
        end else if (pick < 80) begin
            build_frame($urandom_range(14, 80), FILL_RANDOM, int'(ETYPE_ARP), KEEP, KEEP,
                        1'b0);
        end else if (pick < 87) begin
            // non-IP, sometimes one off a known type
            if ($urandom_range(0, 1) == 0)
                etype = int'(ETYPE_IPV4) ^ (1 << $urandom_range(0, 15));
            else
                etype = $urandom_range(0, 65535);
            build_frame($urandom_range(14, 80), FILL_RANDOM, etype, KEEP, KEEP, 1'b0);
        end else if (pick < 93) begin
            // runt
            build_frame($urandom_range(1, 13), FILL_RANDOM, KEEP, KEEP, KEEP, 1'b0);
        end else begin
            // noise: nothing forced
            build_frame($urandom_range(14, 90), FILL_RANDOM, KEEP, KEEP, KEEP, 1'b0);
        end
        send_frame();
    endtask

    task automatic random_phase(int n_bytes);
        int stop_bytes;
        stop_bytes = bytes_in + n_bytes;
        while (bytes_in < stop_bytes)
            random_frame();
    endtask

    // Directed frames: status left at NO_STATUS comes from the local parser
    t_frame_row directed_rows [22] = '{
        '{FILL_ZERO,   14,    KEEP,       KEEP,  KEEP,       ST_NON_IP},     // first after reset
        '{FILL_ONES,   14,    KEEP,       KEEP,  KEEP,       ST_NON_IP},
        '{FILL_RANDOM, 1,     KEEP,       KEEP,  KEEP,       NO_STATUS},     // runt, one byte
        '{FILL_RANDOM, 13,    KEEP,       KEEP,  KEEP,       NO_STATUS},     // runt, longest
        '{FILL_ZERO,   14,    ETYPE_IPV4, KEEP,  KEEP,       ST_IP_TRUNC},
        '{FILL_RANDOM, 33,    ETYPE_IPV4, 8'h45, KEEP,       ST_IP_TRUNC},
        '{FILL_RANDOM, 34,    ETYPE_IPV4, 8'h45, 8'hFF,      ST_IP_OTHER},
        '{FILL_RANDOM, 60,    ETYPE_IPV4, 8'h65, PROTO_TCP,  ST_IP_BAD},     // version 6
        '{FILL_RANDOM, 60,    ETYPE_IPV4, 8'h44, PROTO_TCP,  ST_IP_BAD},     // short IHL
        '{FILL_RANDOM, 60,    ETYPE_IPV4, 8'h40, PROTO_UDP,  ST_IP_BAD},     // IHL zero
        '{FILL_RANDOM, 60,    ETYPE_IPV4, 8'h4F, PROTO_TCP,  ST_IP_BAD},     // header past end
        '{FILL_RANDOM, 94,    ETYPE_IPV4, 8'h4F, PROTO_TCP,  ST_TCP},        // longest header
        '{FILL_RANDOM, 53,    ETYPE_IPV4, 8'h45, PROTO_TCP,  ST_TCP_TRUNC},
        '{FILL_ONES,   54,    ETYPE_IPV4, 8'h45, PROTO_TCP,  ST_TCP},        // all flags set
        '{FILL_RANDOM, 41,    ETYPE_IPV4, 8'h45, PROTO_UDP,  ST_UDP_TRUNC},
        '{FILL_RANDOM, 42,    ETYPE_IPV4, 8'h45, PROTO_UDP,  ST_UDP},
        '{FILL_RANDOM, 41,    ETYPE_IPV4, 8'h45, PROTO_ICMP, ST_ICMP_TRUNC},
        '{FILL_RANDOM, 42,    ETYPE_IPV4, 8'h45, PROTO_ICMP, ST_ICMP},
        '{FILL_RANDOM, 60,    ETYPE_IPV6, KEEP,  KEEP,       ST_IPV6},
        '{FILL_RANDOM, 42,    ETYPE_ARP,  KEEP,  KEEP,       ST_ARP},
        '{FILL_RANDOM, 20,    16'h0801,   KEEP,  KEEP,       ST_NON_IP},
        '{FILL_ONES,   60,    ETYPE_IPV4, 8'h45, PROTO_UDP,  ST_UDP}
    };

    initial begin
        int codes_hit;
        src_idle_pct  = 31;
        sink_idle_pct = 55;
        clear_capture();
        i_rst_n = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed rows under the first idling mix
        foreach (directed_rows[r]) begin
            build_frame(directed_rows[r].len, directed_rows[r].fill, directed_rows[r].etype,
                        directed_rows[r].vihl, directed_rows[r].proto, 1'b0);
            status_override = directed_rows[r].status;
            send_frame();
            status_override = NO_STATUS;
        end
        drain();

        // Long receiver hold-off while short frames keep coming: the frame
        // queue fills and the byte side must stall
        start_hold(400);
        repeat (12) begin
            build_frame($urandom_range(14, 30), FILL_RANDOM,
                        ($urandom_range(0, 1) == 0) ? int'(ETYPE_IPV4) : KEEP,
                        8'h45, KEEP, 1'b0);
            send_frame();
        end
        drain();

        random_phase(180);
        drain();

        src_idle_pct  = 55;
        sink_idle_pct = 31;
        random_phase(180);
        drain();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_phase(180);
        drain();
        repeat (8) @(negedge i_clk);

        if (awaited_headers.size() != 0) begin
            err_count++;
            $display("%0d records never arrived", awaited_headers.size());
        end

        codes_hit = 0;
        foreach (status_hit[s]) codes_hit += status_hit[s];
        $display("Run covered %0d bytes, %0d header records checked, %0d runt frames, %0d at max size",
                 bytes_in, headers_seen, runt_frames, oversized_frames);
        $display("Status codes exercised: %0d of %0d; errors counted: %0d",
                 codes_hit, NUM_STATUS, err_count);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
